// ----- sv/sv39m_pkg.sv -----
// Shared types and constants for the Sv39 page table mapper.
// No dependencies; imported by every module of the block.
`default_nettype none

package sv39m_pkg;

    localparam int PPN_W      = 44;
    localparam int VA_W       = 39;
    localparam int PA_W       = 56;
    localparam int FLAGS_W    = 10;
    localparam int PTE_W      = 64;
    localparam int IDX_W      = 9;
    localparam int ENTRIES    = 512;
    localparam int LVL_W      = 2;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 48;

    localparam logic [PPN_W-1:0] POOL_BASE_RST = 44'd524288;
    localparam logic [LVL_W-1:0] LEVEL_TOP     = 2'd2;
    localparam logic [LVL_W-1:0] LEVEL_MID     = 2'd1;

    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_UNMAP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MISALIGNED = 3'd1,
        ST_MAPPED     = 3'd2,
        ST_EXHAUSTED  = 3'd3,
        ST_SUPERPAGE  = 3'd4,
        ST_NOT_MAPPED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ALLOC_CLR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 mode;
        logic [VA_W-1:0]      virt_addr;
        logic [PA_W-1:0]      phys_addr;
        logic [FLAGS_W-1:0]   leaf_flags;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic                 flush_request;
        logic [VA_W-1:0]      flush_addr;
    } rsp_t;

endpackage

`default_nettype wire

// ----- sv/sv39m_store.sv -----
// Table store: single write port, single read port, registered read data.
// Depends on sv39m_pkg for the PTE width.
`default_nettype none

module sv39m_store #(
    parameter int DEPTH = 32768
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [sv39m_pkg::PTE_W-1:0]      wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [sv39m_pkg::PTE_W-1:0]      rd_data
);
    import sv39m_pkg::*;

    logic [PTE_W-1:0] store_mem [DEPTH];
    logic [PTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= store_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/sv39m_walk.sv -----
// Walk sequencer: three-level table walk, allocation, clearing passes and
// leaf update around one shared 44-bit adder. Depends on sv39m_pkg.
`default_nettype none

module sv39m_walk #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic [sv39m_pkg::PPN_W-1:0]             pool_base,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire sv39m_pkg::req_t                         in_req,
    input  wire logic                                    out_free,
    output logic                                         rsp_valid,
    output sv39m_pkg::rsp_t                              rsp,
    output logic                                         mem_we,
    output logic [$clog2(TABLE_PAGES)+sv39m_pkg::IDX_W-1:0] mem_waddr,
    output logic [sv39m_pkg::PTE_W-1:0]                  mem_wdata,
    output logic                                         mem_re,
    output logic [$clog2(TABLE_PAGES)+sv39m_pkg::IDX_W-1:0] mem_raddr,
    input  wire logic [sv39m_pkg::PTE_W-1:0]             mem_rdata
);
    import sv39m_pkg::*;

    localparam int TW  = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NFW = $clog2(TABLE_PAGES + 1);

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    status_t             status_reg, status_next;
    logic                flush_reg, flush_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [TW-1:0]       tbl_reg, tbl_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [NFW-1:0]      nf_reg, nf_next;

    logic [IDX_W-1:0]    idx;
    logic                misaligned;
    logic                is_map;
    logic                at_leaf;
    logic                pte_v;
    logic                pte_rwx;
    logic                exhausted;
    logic                ptr_ok;
    logic                cnt_last;
    logic [PPN_W-1:0]    add_a;
    logic [PPN_W-1:0]    add_b;
    logic                add_cin;
    logic [PPN_W-1:0]    add_sum;

    always_comb
    begin
        case (level_reg)
            LEVEL_TOP: idx = req_reg.virt_addr[38:30];
            LEVEL_MID: idx = req_reg.virt_addr[29:21];
            default:   idx = req_reg.virt_addr[20:12];
        endcase
    end

    assign misaligned = (in_req.virt_addr[11:0] != 12'd0)
                     || ((in_req.mode == MODE_MAP) && (in_req.phys_addr[11:0] != 12'd0));
    assign is_map    = (req_reg.mode == MODE_MAP);
    assign at_leaf   = (level_reg == '0);
    assign pte_v     = mem_rdata[0];
    assign pte_rwx   = |mem_rdata[3:1];
    assign exhausted = (nf_reg == NFW'(TABLE_PAGES));
    assign cnt_last  = (cnt_reg == IDX_W'(ENTRIES - 1));

    // Shared adder: pointer offset (ppn - base) for a valid entry,
    // new table PPN (base + next free) for an allocation.
    always_comb
    begin
        if (pte_v)
        begin
            add_a   = mem_rdata[10 +: PPN_W];
            add_b   = ~pool_base;
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = pool_base;
            add_b   = PPN_W'(nf_reg);
            add_cin = 1'b0;
        end
    end

    assign add_sum = add_a + add_b + PPN_W'(add_cin);
    assign ptr_ok  = (add_sum < PPN_W'(nf_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT_CLR:
            begin
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = misaligned ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (at_leaf)
                begin
                    state_next = S_DONE;
                end
                else if (!pte_v)
                begin
                    state_next = (is_map && !exhausted) ? S_ALLOC_CLR : S_DONE;
                end
                else if (pte_rwx || !ptr_ok)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_ALLOC_CLR:
            begin
                if (cnt_last)
                begin
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT_CLR;
            end
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        req_next    = req_reg;
        status_next = status_reg;
        flush_next  = flush_reg;
        level_next  = level_reg;
        tbl_next    = tbl_reg;
        cnt_next    = cnt_reg;
        nf_next     = nf_reg;
        in_ready    = 1'b0;
        rsp_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = {tbl_reg, idx};
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = {tbl_reg, idx};
        case (state_reg)
            S_INIT_CLR, S_ALLOC_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {tbl_reg, cnt_reg};
                cnt_next  = cnt_reg + 1'b1;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next    = in_req;
                    level_next  = LEVEL_TOP;
                    tbl_next    = '0;
                    flush_next  = 1'b0;
                    status_next = misaligned ? ST_MISALIGNED : ST_OK;
                end
            end
            S_READ:
            begin
                mem_re = 1'b1;
            end
            S_CHECK:
            begin
                if (at_leaf)
                begin
                    if (is_map)
                    begin
                        if (pte_v)
                        begin
                            status_next = ST_MAPPED;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {10'd0, req_reg.phys_addr[PA_W-1:12],
                                         req_reg.leaf_flags | 10'd1};
                        end
                    end
                    else if (!pte_v)
                    begin
                        status_next = ST_NOT_MAPPED;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        flush_next = 1'b1;
                    end
                end
                else if (!pte_v)
                begin
                    if (!is_map)
                    begin
                        status_next = ST_NOT_MAPPED;
                    end
                    else if (exhausted)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        // link the new table, then clear it before descending
                        mem_we     = 1'b1;
                        mem_wdata  = {10'd0, add_sum, 10'd1};
                        nf_next    = nf_reg + 1'b1;
                        tbl_next   = nf_reg[TW-1:0];
                        level_next = level_reg - 1'b1;
                        cnt_next   = '0;
                    end
                end
                else if (pte_rwx || !ptr_ok)
                begin
                    status_next = is_map ? ST_SUPERPAGE : ST_NOT_MAPPED;
                end
                else
                begin
                    tbl_next   = add_sum[TW-1:0];
                    level_next = level_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                rsp_valid = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign rsp.status        = status_reg;
    assign rsp.flush_request = flush_reg;
    assign rsp.flush_addr    = flush_reg ? req_reg.virt_addr : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            level_reg <= LEVEL_TOP;
            tbl_reg   <= '0;
            cnt_reg   <= '0;
            nf_reg    <= NFW'(1);
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            tbl_reg   <= tbl_next;
            cnt_reg   <= cnt_next;
            nf_reg    <= nf_next;
            flush_reg <= flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
    end

    a_rsp_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> out_free)
        else $error("result issued while output register busy");

    a_pool_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg <= NFW'(TABLE_PAGES)) && (nf_reg != '0))
        else $error("pool counter out of range");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("store read and written in the same cycle");

endmodule

`default_nettype wire

// ----- sv/sv39_page_table_mapper.sv -----
// Top level of the Sv39 page table mapper: config register, stream ports,
// output register. Depends on sv39m_pkg, sv39m_store and sv39m_walk.
//
//   channel  | direction | signals                          | contents
//   cfg      | in        | cfg_we, cfg_wdata[43:0]          | pool_base_ppn
//   s_axis   | in        | tvalid/tready, tdata, tuser      | map/unmap request
//   m_axis   | out       | tvalid/tready, tdata, tuser      | status and flush
//
// A request that walks down to the leaf with no table allocation makes three
// read/check rounds of the table store between accept and issue; one that stops
// at the top or middle level makes one or two, and a misaligned request goes
// straight from accept to issue. Each newly allocated table adds a clearing
// pass over its 512 entries, one store entry per cycle. After reset the root
// table is cleared before s_axis_tready rises. A result waits in the output
// register while the next request is taken; a finished request holds off the
// next accept while that register is full and m_axis_tready is low.
`default_nettype none

module sv39_page_table_mapper #(
    parameter int TABLE_PAGES = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [sv39m_pkg::PPN_W-1:0]           cfg_wdata,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [38:0] virt_addr, [94:39] phys_addr, [104:95] leaf_flags, [111:105] zero
    input  wire logic [sv39m_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] mode
    input  wire logic [0:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [2:0] status, [41:3] flush_addr, [47:42] zero
    output logic      [sv39m_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // [0] flush_request
    output logic      [0:0]                            m_axis_tuser
);
    import sv39m_pkg::*;

    localparam int TW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * ENTRIES;

    logic [PPN_W-1:0] pool_base_reg;
    logic             out_valid_reg, out_valid_next;
    rsp_t             rsp_reg, rsp_next;

    req_t             in_req;
    rsp_t             rsp;
    logic             rsp_valid;
    logic             out_free;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PTE_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [PTE_W-1:0] mem_rdata;

    assign in_req.mode       = s_axis_tuser[0];
    assign in_req.virt_addr  = s_axis_tdata[38:0];
    assign in_req.phys_addr  = s_axis_tdata[94:39];
    assign in_req.leaf_flags = s_axis_tdata[104:95];

    assign out_free = !out_valid_reg || m_axis_tready;

    sv39m_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_base (pool_base_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (in_req),
        .out_free  (out_free),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sv39m_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid)
        begin
            out_valid_next = 1'b1;
            rsp_next       = rsp;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= POOL_BASE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pool_base_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, rsp_reg.flush_addr, rsp_reg.status};
    assign m_axis_tuser  = rsp_reg.flush_request;

endmodule

`default_nettype wire
